FILE: src/mqf_pkg.sv
// ----------------------------------------------------------------------------
// mqf_pkg
// Types, constants and lookup functions of the time code quarter-frame
// receiver.
// ----------------------------------------------------------------------------
package mqf_pkg;

   // Width of the shared add/subtract unit (32-bit values plus guard bits)
   localparam int ALU_W = 34;

   // Input operation codes
   localparam logic OP_PIECE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_RECEIVE_ENABLE = 2'd0;
   localparam logic [1:0] CSR_RECEIVE_OFFSET = 2'd1;

   // Time conversion constants
   localparam int FRAME_MS      = 1000;
   localparam int MINUTE_MS     = 60000;
   localparam int HOUR_MS       = 3600000;
   localparam int HOUR_LIMIT    = 20;
   localparam int START_WINDOW  = 100;
   localparam int DIV_STEPS     = 15;

   // Drift window on ticks: stop if external - clock leaves [LATE, EARLY]
   localparam logic signed [ALU_W-1:0] LATE_LIMIT  = -34'sd500;
   localparam logic signed [ALU_W-1:0] EARLY_LIMIT = 34'sd1000;

   typedef enum logic [1:0] {
      REQ_NONE     = 2'd0,
      REQ_START    = 2'd1,
      REQ_CONTINUE = 2'd2,
      REQ_STOP     = 2'd3
   } request_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_ACC,
      S_FIN,
      S_TICK,
      S_DONE
   } state_type;

   // Operands of the shared unit
   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

   // Frame rate for a code type
   function automatic logic [4:0] rate_fps(input logic [1:0] ct);
      logic [4:0] r;
      unique case (ct)
         2'd0:    r = 5'd24;
         2'd1:    r = 5'd25;
         default: r = 5'd30;
      endcase
      return r;
   endfunction

   // Two-frame delay in milliseconds for a code type
   function automatic logic [6:0] delay_ms(input logic [1:0] ct);
      logic [6:0] d;
      unique case (ct)
         2'd0:    d = 7'd83;
         2'd1:    d = 7'd80;
         default: d = 7'd67;
      endcase
      return d;
   endfunction

endpackage

FILE: src/mqf_alu.sv
// ----------------------------------------------------------------------------
// mqf_alu
// Shared add/subtract unit used by the division, accumulate and tick steps of the sequencer.
// ----------------------------------------------------------------------------
module mqf_alu (
   input  mqf_pkg::alu_req_type     op,
   output logic [mqf_pkg::ALU_W-1:0] result
);
   import mqf_pkg::*;

   // Add, or subtract by two's complement
   always_comb begin
      if (op.sub) begin
         result = op.a + ~op.b + ALU_W'(1);
      end else begin
         result = op.a + op.b;
      end
   end

endmodule

FILE: src/mtc_quarter_frame_receiver.sv
// ----------------------------------------------------------------------------
// mtc_quarter_frame_receiver
// Collects quarter-frame pieces into a millisecond time and checks drift
// against the sequencer clock on millisecond ticks.
//
//   channel  handshake                         payload
//   req      req_valid / req_ready             operation, piece, clock, delay
//   rsp      rsp_valid / rsp_ready             time, completed, request, drift
//   csr      csr_write_enable (no wait)        csr_index, csr_write_data
//
// A completing piece 7 runs 15 restoring division steps for the frame term
// and 5 accumulate steps, all on the one shared adder, then finish and
// hand-off. Other pieces go straight to hand-off; ticks take a drift step first.
// One word is in work at a time; req_ready is low until its result moves to
// the output register, which holds while rsp_ready is low.
// Reset is synchronous and clears configuration, pieces, state, sync and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module mtc_quarter_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [2:0]  req_piece_index,
   input  logic [3:0]  req_piece_nibble,
   input  logic [31:0] req_internal_clock_ms,
   input  logic [31:0] req_caller_delay_ms,
   input  logic        req_sequencer_playing,
   input  logic        req_sequencer_winding,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_external_time_ms,
   output logic        rsp_time_completed,
   output logic [1:0]  rsp_transport_request,
   output logic [31:0] rsp_drift_ms,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [27:0] csr_write_data
);
   import mqf_pkg::*;

   // Configuration
   logic        enable_ff;
   logic [27:0] offset_ff;

   // Block state
   logic [3:0]  store_ff [8];
   logic        locked_ff;
   logic [31:0] ext_ff, ext_in;
   logic [31:0] last_seen_ff, last_seen_in;
   logic        sync_ff, sync_in;

   // Sequencer and working registers
   state_type   state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [14:0] num_ff, num_in;
   logic [14:0] quo_ff, quo_in;
   logic [4:0]  rem_ff, rem_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  ct_ff;
   logic        playing_ff, winding_ff;
   logic [31:0] clk_ff, cdelay_ff;

   // Result staging
   logic        res_done_ff, res_done_in;
   request_type res_req_ff, res_req_in;
   logic [31:0] res_drift_ff, res_drift_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_time_ff;
   logic        rsp_done_ff;
   request_type rsp_req_ff;
   logic [31:0] rsp_drift_ff;
   logic        rsp_load;

   logic        accept;
   alu_req_type alu_op;
   logic [ALU_W-1:0] alu_res;

   // Decoded fields of the stored pieces
   logic [4:0]  frames;
   logic [5:0]  seconds, minutes;
   logic [4:0]  hours;

   assign accept  = req_valid && req_ready;
   assign frames  = {store_ff[1][0], store_ff[0]};
   assign seconds = {store_ff[3][1:0], store_ff[2]};
   assign minutes = {store_ff[5][1:0], store_ff[4]};
   assign hours   = {store_ff[7][0], store_ff[6]};

   mqf_alu u_alu (
      .op     (alu_op),
      .result (alu_res)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         offset_ff <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_RECEIVE_ENABLE) begin
            enable_ff <= csr_write_data[0];
         end
         if (csr_index == CSR_RECEIVE_OFFSET) begin
            offset_ff <= csr_write_data;
         end
      end
   end

   // Store pieces and latch the word at accept
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            store_ff[i] <= '0;
         end
         locked_ff <= 1'b0;
      end else if (accept && req_operation == OP_PIECE && enable_ff) begin
         store_ff[req_piece_index] <= req_piece_nibble;
         if (req_piece_index == 3'd0) begin
            locked_ff <= 1'b1;
         end else if (req_piece_index == 3'd7) begin
            locked_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ct_ff      <= req_piece_nibble[2:1];
         playing_ff <= req_sequencer_playing;
         winding_ff <= req_sequencer_winding;
         clk_ff     <= req_internal_clock_ms;
         cdelay_ff  <= req_caller_delay_ms;
      end
   end

   // Operand selection for the shared unit
   always_comb begin
      alu_op = '{a: '0, b: '0, sub: 1'b0};
      unique case (state_ff)
         S_DIV: begin
            alu_op.a   = ALU_W'({rem_ff, num_ff[14]});
            alu_op.b   = ALU_W'(rate_fps(ct_ff));
            alu_op.sub = 1'b1;
         end
         S_ACC: begin
            alu_op.a = ALU_W'(acc_ff);
            unique case (cnt_ff)
               4'd0: begin
                  alu_op.a = ALU_W'(quo_ff);
                  alu_op.b = ALU_W'(seconds) * ALU_W'(FRAME_MS);
               end
               4'd1: alu_op.b = ALU_W'(minutes) * ALU_W'(MINUTE_MS);
               4'd2: alu_op.b = ALU_W'(hours) * ALU_W'(HOUR_MS);
               4'd3: alu_op.b = ALU_W'(delay_ms(ct_ff));
               default: begin
                  alu_op.b   = ALU_W'($signed(offset_ff));
                  alu_op.sub = 1'b1;
               end
            endcase
         end
         S_TICK: begin
            alu_op.a   = ALU_W'($signed(ext_ff));
            alu_op.b   = ALU_W'($signed(clk_ff));
            alu_op.sub = 1'b1;
         end
         default: ;
      endcase
   end

   // Sequencer: next state and working values
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      ext_in       = ext_ff;
      last_seen_in = last_seen_ff;
      sync_in      = sync_ff;
      res_done_in  = res_done_ff;
      res_req_in   = res_req_ff;
      res_drift_in = res_drift_ff;
      rsp_load     = 1'b0;
      req_ready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_done_in  = 1'b0;
               res_req_in   = REQ_NONE;
               res_drift_in = '0;
               if (req_operation == OP_TICK) begin
                  state_in = S_TICK;
               end else if (enable_ff && locked_ff && req_piece_index == 3'd7) begin
                  // frames * 1000, divided below by the frame rate
                  num_in   = 15'(frames * 15'(FRAME_MS));
                  quo_in   = '0;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = S_DIV;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DIV: begin
            // Keep the trial remainder when it did not go negative
            if (alu_res[ALU_W-1]) begin
               rem_in = {rem_ff[3:0], num_ff[14]};
            end else begin
               rem_in = alu_res[4:0];
            end
            quo_in = {quo_ff[13:0], ~alu_res[ALU_W-1]};
            num_in = {num_ff[13:0], 1'b0};
            if (cnt_ff == 4'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_ACC;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_ACC: begin
            // Drop the whole decoded time when hours are out of range
            if (cnt_ff == 4'd2 && hours > 5'(HOUR_LIMIT)) begin
               acc_in = '0;
            end else begin
               acc_in = alu_res[31:0];
            end
            if (cnt_ff == 4'd4) begin
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_FIN: begin
            ext_in      = acc_ff;
            res_done_in = 1'b1;
            if (!sync_ff && !playing_ff && !acc_ff[31] && !winding_ff) begin
               sync_in    = 1'b1;
               res_req_in = (acc_ff < 32'(START_WINDOW)) ? REQ_START : REQ_CONTINUE;
            end
            state_in = S_DONE;
         end
         S_TICK: begin
            if ($signed(alu_res) < LATE_LIMIT || $signed(alu_res) > EARLY_LIMIT) begin
               sync_in    = 1'b0;
               res_req_in = REQ_STOP;
            end
            if (last_seen_ff != ext_ff) begin
               res_drift_in = alu_res[31:0];
               last_seen_in = ext_ff;
            end else begin
               res_drift_in = cdelay_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hand off once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ext_ff       <= '0;
         last_seen_ff <= '1;
         sync_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ext_ff       <= ext_in;
         last_seen_ff <= last_seen_in;
         sync_ff      <= sync_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      num_ff       <= num_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      acc_ff       <= acc_in;
      res_done_ff  <= res_done_in;
      res_req_ff   <= res_req_in;
      res_drift_ff <= res_drift_in;
   end

   // Output register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_time_ff  <= ext_ff;
         rsp_done_ff  <= res_done_ff;
         rsp_req_ff   <= res_req_ff;
         rsp_drift_ff <= res_drift_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_external_time_ms  = rsp_time_ff;
   assign rsp_time_completed    = rsp_done_ff;
   assign rsp_transport_request = rsp_req_ff;
   assign rsp_drift_ms          = rsp_drift_ff;

`ifndef SYNTHESIS
   // One word in work at a time
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("new word taken while one is in work");

   // A completed time never comes with a stop request
   a_no_stop_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_time_completed && rsp_transport_request == REQ_STOP))
      else $error("stop request on a completed time");

   // Division runs a bounded number of steps
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff < 4'(DIV_STEPS))
      else $error("division step count out of range");

   // The output register is loaded only when free or draining
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");
`endif

endmodule

FILE: sim/mqf_time_checker.sv
// ----------------------------------------------------------------------------
// mqf_time_checker
// Watches the request, response and register ports of the quarter-frame
// receiver, keeps its own model of the decoder state, and compares every
// response word with the word predicted for the oldest accepted request.
// ----------------------------------------------------------------------------
module mqf_time_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_operation,
   input  logic [2:0]  req_piece_index,
   input  logic [3:0]  req_piece_nibble,
   input  logic [31:0] req_internal_clock_ms,
   input  logic [31:0] req_caller_delay_ms,
   input  logic        req_sequencer_playing,
   input  logic        req_sequencer_winding,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_external_time_ms,
   input  logic        rsp_time_completed,
   input  logic [1:0]  rsp_transport_request,
   input  logic [31:0] rsp_drift_ms,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [27:0] csr_write_data,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import mqf_pkg::*;

   // Time code types carried in bits 2..1 of the last piece
   typedef enum logic [1:0] {
      CODE_24FPS   = 2'd0,
      CODE_25FPS   = 2'd1,
      CODE_30_DROP = 2'd2,
      CODE_30FPS   = 2'd3
   } code_rate_type;

   localparam logic [2:0] LOCK_PIECE = 3'd0;
   localparam logic [2:0] LAST_PIECE = 3'd7;
   localparam int SECOND_MS       = 1000;
   localparam int MIN_MS          = 60000;
   localparam int HR_MS           = 3600000;
   localparam int MAX_HOURS       = 20;
   localparam int START_BELOW     = 100;
   localparam longint LATE_MARGIN = 500;
   localparam longint EARLY_MARGIN = 1000;

   typedef struct packed {
      logic [31:0] external_time_ms;
      logic        time_completed;
      request_type transport_request;
      logic [31:0] drift_ms;
   } mtc_word_type;

   // Model state and register copies
   logic [3:0]  nibble_store [8];
   logic        armed;
   logic [31:0] ext_time;
   logic [31:0] last_reported;
   logic        engaged;
   logic        rx_enable;
   logic [27:0] rx_offset;

   mtc_word_type expected_words [$];
   int           fail_total = 0;

   // Convert the eight stored nibbles to milliseconds with delay and offset
   function automatic logic [31:0] timecode_to_ms();
      code_rate_type code;
      logic [31:0]   frames, secs, mins, hours, fps, late, ms;
      code   = code_rate_type'(nibble_store[7][2:1]);
      frames = {27'd0, nibble_store[1][0], nibble_store[0]};
      secs   = {26'd0, nibble_store[3][1:0], nibble_store[2]};
      mins   = {26'd0, nibble_store[5][1:0], nibble_store[4]};
      hours  = {27'd0, nibble_store[7][0], nibble_store[6]};
      case (code)
         CODE_24FPS: begin
            fps  = 32'd24;
            late = 32'd83;
         end
         CODE_25FPS: begin
            fps  = 32'd25;
            late = 32'd80;
         end
         default: begin
            fps  = 32'd30;
            late = 32'd67;
         end
      endcase
      ms = (frames * SECOND_MS) / fps + secs * SECOND_MS + mins * MIN_MS;
      // past the hour limit the whole decoded time is zero
      if (hours > MAX_HOURS) ms = 32'd0;
      else ms = ms + hours * HR_MS;
      return ms + late - {{4{rx_offset[27]}}, rx_offset};
   endfunction

   // Advance the model by one request word and return the expected response
   function automatic mtc_word_type predict_word(
      input logic        op,
      input logic [2:0]  idx,
      input logic [3:0]  nib,
      input logic [31:0] clk_ms,
      input logic [31:0] delay,
      input logic        playing,
      input logic        winding
   );
      mtc_word_type w;
      longint       ext, clk;
      w.time_completed    = 1'b0;
      w.transport_request = REQ_NONE;
      w.drift_ms          = 32'd0;
      if (op == OP_PIECE) begin
         if (rx_enable) begin
            if (idx == LOCK_PIECE) armed = 1'b1;
            nibble_store[idx] = nib;
            if (armed && idx == LAST_PIECE) begin
               ext_time         = timecode_to_ms();
               armed            = 1'b0;
               w.time_completed = 1'b1;
               if (!engaged && !playing && !ext_time[31] && !winding) begin
                  engaged = 1'b1;
                  w.transport_request = ($signed(ext_time) < START_BELOW) ?
                                        REQ_START : REQ_CONTINUE;
               end
            end
         end
      end else begin
         ext = longint'($signed(ext_time));
         clk = longint'($signed(clk_ms));
         // outside the drift window: drop sync and ask for stop
         if (ext + LATE_MARGIN < clk || ext - EARLY_MARGIN > clk) begin
            engaged             = 1'b0;
            w.transport_request = REQ_STOP;
         end
         if (last_reported != ext_time) begin
            w.drift_ms    = ext_time - clk_ms;
            last_reported = ext_time;
         end else begin
            w.drift_ms = delay;
         end
      end
      w.external_time_ms = ext_time;
      return w;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_total++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   // Track registers, compare responses, then queue the new prediction
   always @(posedge clock) begin : watch
      mtc_word_type want;
      if (reset) begin
         for (int i = 0; i < 8; i++) nibble_store[i] = 4'd0;
         armed         = 1'b0;
         ext_time      = 32'd0;
         last_reported = 32'hFFFF_FFFF;
         engaged       = 1'b0;
         rx_enable     = 1'b0;
         rx_offset     = 28'd0;
         expected_words.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RECEIVE_ENABLE: rx_enable = csr_write_data[0];
               CSR_RECEIVE_OFFSET: rx_offset = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               fail_total++;
               $display("%0t: unexpected response word, expected none, actual %h %b %0d %h",
                        $time, rsp_external_time_ms, rsp_time_completed,
                        rsp_transport_request, rsp_drift_ms);
            end else begin
               want = expected_words.pop_front();
               check_field("external_time_ms", want.external_time_ms, rsp_external_time_ms);
               check_field("time_completed", 32'(want.time_completed),
                           32'(rsp_time_completed));
               check_field("transport_request", 32'(want.transport_request),
                           32'(rsp_transport_request));
               check_field("drift_ms", want.drift_ms, rsp_drift_ms);
            end
         end
         if (req_valid && req_ready) begin
            expected_words.push_back(predict_word(req_operation, req_piece_index,
               req_piece_nibble, req_internal_clock_ms, req_caller_delay_ms,
               req_sequencer_playing, req_sequencer_winding));
         end
      end
      fail_count    <= fail_total;
      pending_count <= expected_words.size();
   end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the quarter-frame receiver with directed and random time code
// sequences, ticks and register settings, with random idling on both sides,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mqf_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 8;
   localparam int PHASE_WORDS  = 105;
   localparam int NUM_PHASES   = 6;
   localparam int OFFSET_MAX   = 86400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = OP_PIECE;
   logic [2:0]  req_piece_index = 3'd0;
   logic [3:0]  req_piece_nibble = 4'd0;
   logic [31:0] req_internal_clock_ms = 32'd0;
   logic [31:0] req_caller_delay_ms = 32'd0;
   logic        req_sequencer_playing = 1'b0;
   logic        req_sequencer_winding = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_external_time_ms;
   logic        rsp_time_completed;
   logic [1:0]  rsp_transport_request;
   logic [31:0] rsp_drift_ms;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_RECEIVE_ENABLE;
   logic [27:0] csr_write_data = 28'd0;

   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int          words_sent = 0;
   int          rsp_hold = 0;
   logic        steady = 1'b0;
   logic [31:0] seen_time = 32'd0;

   mtc_quarter_frame_receiver i_dut (.*);

   mqf_time_checker i_checker (.*);

   always #4 clock = ~clock;

   // Hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, 4);
   endfunction

   // Response side: after each word, may drop rsp_ready for a random stall
   always @(posedge clock) begin : rsp_side
      int wait_cycles;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         seen_time   <= rsp_external_time_ms;
         wait_cycles = draw_wait();
         if (wait_cycles != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= wait_cycles - 1;
         end
      end else if (!rsp_ready) begin
         if (rsp_hold == 0) rsp_ready <= 1'b1;
         else rsp_hold <= rsp_hold - 1;
      end
   end

   // Write one register while the block is idle
   task automatic write_csr(input logic [1:0] idx, input logic [27:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Present one request word after a random gap and hold it until accepted
   task automatic send_word(input logic op, input logic [2:0] idx, input logic [3:0] nib,
                            input logic [31:0] clk_ms, input logic [31:0] delay,
                            input logic playing, input logic winding);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_operation         <= op;
      req_piece_index       <= idx;
      req_piece_nibble      <= nib;
      req_internal_clock_ms <= clk_ms;
      req_caller_delay_ms   <= delay;
      req_sequencer_playing <= playing;
      req_sequencer_winding <= winding;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   function automatic logic [31:0] any_word();
      return $urandom;
   endfunction

   // Send pieces 0..7 of one time code; unused nibble bits are random
   task automatic send_timecode(input logic [4:0] fr, input logic [5:0] se,
                                input logic [5:0] mi, input logic [4:0] hr,
                                input logic [1:0] code, input logic playing,
                                input logic winding);
      logic [3:0] nib [8];
      nib[0] = fr[3:0];
      nib[1] = {3'($urandom), fr[4]};
      nib[2] = se[3:0];
      nib[3] = {2'($urandom), se[5:4]};
      nib[4] = mi[3:0];
      nib[5] = {2'($urandom), mi[5:4]};
      nib[6] = hr[3:0];
      nib[7] = {1'($urandom), code, hr[4]};
      for (int i = 0; i < 8; i++)
         send_word(OP_PIECE, 3'(i), nib[i], any_word(), any_word(), playing, winding);
   endtask

   // Hold off until every response has come back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      int          pick, start, len, phase;
      logic [27:0] offset;
      logic        en;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reception off: pieces change nothing, ticks still report drift
      send_word(OP_PIECE, 3'd0, 4'hF, 32'd0, 32'd0, 1'b0, 1'b0);
      send_word(OP_PIECE, 3'd7, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_word(OP_TICK, 3'd0, 4'd0, 32'd0, 32'h8000_0000, 1'b0, 1'b0);
      drain();

      write_csr(CSR_RECEIVE_ENABLE, 28'd1);
      write_csr(CSR_RECEIVE_OFFSET, 28'd0);

      // Zero time code requests start; then window edges and a stop
      send_timecode(5'd0, 6'd0, 6'd0, 5'd0, 2'd0, 1'b0, 1'b0);
      send_word(OP_TICK, 3'd7, 4'hF, 32'd583, 32'd0, 1'b1, 1'b1);
      send_word(OP_TICK, 3'd0, 4'd0, -32'sd917, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send_word(OP_TICK, 3'd0, 4'd0, 32'd584, 32'd0, 1'b0, 1'b0);
      // Last piece without a lock stores only
      send_word(OP_PIECE, 3'd7, 4'h6, 32'd0, 32'd0, 1'b0, 1'b0);
      // Hours above the limit while winding: decoded time dropped, no request
      send_timecode(5'd31, 6'd63, 6'd63, 5'd31, 2'd3, 1'b0, 1'b1);
      send_word(OP_TICK, 3'd5, 4'hA, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
      drain();

      // Random phases, each under its own register setting
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         en = 1'b1;
         case (phase)
            0: offset = 28'd0;
            1: offset = 28'(OFFSET_MAX);
            2: offset = 28'(-OFFSET_MAX);
            3: begin
               en     = 1'b0;
               offset = 28'($urandom_range(0, 2 * OFFSET_MAX) - OFFSET_MAX);
            end
            4: offset = 28'($urandom_range(0, 2 * OFFSET_MAX) - OFFSET_MAX);
            default: offset = 28'd50;
         endcase
         write_csr(CSR_RECEIVE_ENABLE, {27'($urandom), en});
         write_csr(CSR_RECEIVE_OFFSET, offset);
         start = words_sent;
         while (words_sent - start < PHASE_WORDS) begin
            if ($urandom_range(0, 39) == 0) steady <= !steady;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               // full run of time code pieces, now and then close to zero
               if ($urandom_range(0, 7) == 0)
                  send_timecode(5'($urandom_range(0, 3)), 6'd0, 6'd0, 5'd0,
                                2'($urandom), $urandom_range(0, 3) == 0,
                                $urandom_range(0, 3) == 0);
               else
                  send_timecode(5'($urandom), 6'($urandom), 6'($urandom),
                                ($urandom_range(0, 4) == 0) ? 5'($urandom_range(21, 31))
                                                            : 5'($urandom_range(0, 20)),
                                2'($urandom), $urandom_range(0, 3) == 0,
                                $urandom_range(0, 3) == 0);
            end else if (pick < 80) begin
               // tick near the drift window, or anywhere
               send_word(OP_TICK, 3'($urandom), 4'($urandom),
                         ($urandom_range(0, 9) < 7) ?
                            seen_time + 32'($urandom_range(0, 1510)) - 32'd1005 :
                            any_word(),
                         any_word(), 1'($urandom), 1'($urandom));
            end else begin
               // broken run of pieces from any index
               len = $urandom_range(1, 7);
               for (int k = $urandom_range(0, 7), n = 0; n < len; k++, n++)
                  send_word(OP_PIECE, 3'(k), 4'($urandom), any_word(), any_word(),
                            1'($urandom), 1'($urandom));
            end
         end
         drain();
      end

      steady <= 1'b0;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
